[hdl/swd_pe_pkg.sv]
// ----------------------------------------------------------------------------
// swd_pe_pkg
// Shared types and constants for the SWD host packet engine.
// ----------------------------------------------------------------------------
package swd_pe_pkg;

    localparam int RESET_HIGH_CYCLES = 64;
    localparam int RESET_IDLE_CYCLES = 8;

    localparam int BIT_COUNT_W = 7;
    localparam int DATA_W      = 32;
    localparam int RETRY_W     = 8;
    localparam int STATUS_W    = 3;
    localparam int PHASE_W     = 4;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic [RETRY_W-1:0] DEFAULT_RETRY_RST = 8'd100;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_XFER  = 2'd1;
    localparam logic [1:0] OP_LRST  = 2'd2;

    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_WAIT  = 3'd2;
    localparam logic [2:0] ACK_FAULT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT_OUT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ACK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PARITY_ERR = 3'd4;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LEAD    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_REQ     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_TRN_ACK = 4'd3;
    localparam logic [PHASE_W-1:0] PH_ACK     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_RDATA   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RPAR    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TRN_WR  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WDATA   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_WPAR    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_END     = 4'd10;
    localparam logic [PHASE_W-1:0] PH_LR_HIGH = 4'd11;
    localparam logic [PHASE_W-1:0] PH_LR_LOW  = 4'd12;

    typedef struct packed {
        logic                swdio_in;
        logic [RETRY_W-1:0]  retry_limit;
        logic [DATA_W-1:0]   wr_word;
        logic [1:0]          reg_addr;
        logic                read_not_write;
        logic                ap_not_dp;
        logic [1:0]          operation;
    } swd_pe_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   rd_word;
        logic [STATUS_W-1:0] status;
        logic                done_res;
        logic                busy_res;
        logic                swdio_oe;
        logic                swdio_out;
    } swd_pe_result_t;

endpackage

[hdl/swd_pe_in_stage.sv]
// ----------------------------------------------------------------------------
// swd_pe_in_stage
// Input register for command/sample requests ahead of the protocol core.
// ----------------------------------------------------------------------------
module swd_pe_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  swd_pe_pkg::swd_pe_item_t in_item,
    output logic                    item_valid,
    input  logic                    item_ready,
    output swd_pe_pkg::swd_pe_item_t item
);
    import swd_pe_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    swd_pe_item_t item_reg;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

[hdl/swd_pe_core.sv]
// ----------------------------------------------------------------------------
// swd_pe_core
// SWD transfer and line reset sequencer, one SWCLK period per request,
// with registered result output.
// ----------------------------------------------------------------------------
module swd_pe_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [7:0]                cfg_wdata,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  swd_pe_pkg::swd_pe_item_t   item,
    output logic                      res_valid,
    input  logic                      res_ready,
    output swd_pe_pkg::swd_pe_result_t res
);
    import swd_pe_pkg::*;

    logic [RETRY_W-1:0]     default_retry_reg;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [BIT_COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [7:0]             request_byte_reg, request_byte_next;
    logic [DATA_W-1:0]      data_shift_reg, data_shift_next;
    logic [2:0]             ack_bits_reg, ack_bits_next;
    logic [RETRY_W-1:0]     retries_left_reg, retries_left_next;
    logic                   parity_acc_reg, parity_acc_next;
    logic [STATUS_W-1:0]    final_status_reg, final_status_next;
    logic                   res_valid_reg;
    swd_pe_result_t         res_reg, res_next;

    logic                   fire;
    logic                   req_parity;
    logic [RETRY_W-1:0]     retry_sel;
    logic [BIT_COUNT_W-1:0] bit_count_inc;
    logic [2:0]             ack_now;
    logic [RETRY_W-1:0]     retries_dec;

    assign item_ready = !res_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign req_parity = item.ap_not_dp ^ item.read_not_write ^ item.reg_addr[0]
                        ^ item.reg_addr[1];
    assign retry_sel  = (item.retry_limit != '0) ? item.retry_limit : default_retry_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        request_byte_next = request_byte_reg;
        data_shift_next   = data_shift_reg;
        ack_bits_next     = ack_bits_reg;
        retries_left_next = retries_left_reg;
        parity_acc_next   = parity_acc_reg;
        final_status_next = final_status_reg;

        res_next.swdio_out = 1'b0;
        res_next.swdio_oe  = 1'b1;
        res_next.busy_res  = 1'b1;
        res_next.done_res  = 1'b0;
        res_next.status    = ST_OK;
        res_next.rd_word   = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.operation == OP_XFER)
            begin
                request_byte_next = {1'b1, 1'b0, req_parity, item.reg_addr,
                                     item.read_not_write, item.ap_not_dp, 1'b1};
                data_shift_next   = item.wr_word;
                retries_left_next = (retry_sel != '0) ? retry_sel : RETRY_W'(1);
                final_status_next = ST_OK;
                phase_next        = PH_LEAD;
            end
            else if (item.operation == OP_LRST)
            begin
                bit_count_next    = '0;
                final_status_next = ST_OK;
                phase_next        = PH_LR_HIGH;
            end
        end

        bit_count_inc = bit_count_next + BIT_COUNT_W'(1);
        ack_now       = ack_bits_next | ({2'b00, item.swdio_in} << bit_count_next[1:0]);
        retries_dec   = retries_left_next - RETRY_W'(1);

        case (phase_next)
            PH_LEAD:
            begin
                bit_count_next = '0;
                phase_next     = PH_REQ;
            end
            PH_REQ:
            begin
                res_next.swdio_out = request_byte_next[bit_count_next[2:0]];
                bit_count_next     = bit_count_inc;
                if (bit_count_inc >= BIT_COUNT_W'(8))
                begin
                    phase_next = PH_TRN_ACK;
                end
            end
            PH_TRN_ACK:
            begin
                res_next.swdio_oe = 1'b0;
                bit_count_next    = '0;
                ack_bits_next     = '0;
                phase_next        = PH_ACK;
            end
            PH_ACK:
            begin
                res_next.swdio_oe = 1'b0;
                ack_bits_next     = ack_now;
                bit_count_next    = bit_count_inc;
                if (bit_count_inc >= BIT_COUNT_W'(3))
                begin
                    bit_count_next  = '0;
                    parity_acc_next = 1'b0;
                    if (ack_now == ACK_WAIT)
                    begin
                        retries_left_next = retries_dec;
                        if (retries_dec != '0)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else
                        begin
                            final_status_next = ST_WAIT_OUT;
                            phase_next        = PH_END;
                        end
                    end
                    else if (ack_now == ACK_OK)
                    begin
                        phase_next = request_byte_next[2] ? PH_RDATA : PH_TRN_WR;
                    end
                    else if (ack_now == ACK_FAULT)
                    begin
                        final_status_next = ST_FAULT;
                        phase_next        = PH_END;
                    end
                    else
                    begin
                        final_status_next = ST_BAD_ACK;
                        phase_next        = PH_END;
                    end
                end
            end
            PH_RDATA:
            begin
                res_next.swdio_oe = 1'b0;
                data_shift_next   = {item.swdio_in, data_shift_next[DATA_W-1:1]};
                parity_acc_next   = parity_acc_next ^ item.swdio_in;
                bit_count_next    = bit_count_inc;
                if (bit_count_inc >= BIT_COUNT_W'(DATA_W))
                begin
                    phase_next = PH_RPAR;
                end
            end
            PH_RPAR:
            begin
                res_next.swdio_oe = 1'b0;
                if (parity_acc_next ^ item.swdio_in)
                begin
                    final_status_next = ST_PARITY_ERR;
                end
                phase_next = PH_END;
            end
            PH_TRN_WR:
            begin
                res_next.swdio_oe = 1'b0;
                bit_count_next    = '0;
                phase_next        = PH_WDATA;
            end
            PH_WDATA:
            begin
                res_next.swdio_out = data_shift_next[0];
                parity_acc_next    = parity_acc_next ^ data_shift_next[0];
                data_shift_next    = {1'b0, data_shift_next[DATA_W-1:1]};
                bit_count_next     = bit_count_inc;
                if (bit_count_inc >= BIT_COUNT_W'(DATA_W))
                begin
                    phase_next = PH_WPAR;
                end
            end
            PH_WPAR:
            begin
                res_next.swdio_out = parity_acc_next;
                phase_next         = PH_END;
            end
            PH_END:
            begin
                res_next.done_res = 1'b1;
                res_next.status   = final_status_next;
                if (final_status_next == ST_OK && request_byte_next[2])
                begin
                    res_next.rd_word = data_shift_next;
                end
                phase_next = PH_IDLE;
            end
            PH_LR_HIGH:
            begin
                res_next.swdio_out = 1'b1;
                bit_count_next     = bit_count_inc;
                if (bit_count_inc >= BIT_COUNT_W'(RESET_HIGH_CYCLES))
                begin
                    bit_count_next = '0;
                    phase_next     = PH_LR_LOW;
                end
            end
            PH_LR_LOW:
            begin
                bit_count_next = bit_count_inc;
                if (bit_count_inc >= BIT_COUNT_W'(RESET_IDLE_CYCLES))
                begin
                    bit_count_next    = '0;
                    res_next.done_res = 1'b1;
                    phase_next        = PH_IDLE;
                end
            end
            default:
            begin
                res_next.busy_res = 1'b0;
                phase_next        = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_retry_reg <= DEFAULT_RETRY_RST;
        end
        else if (cfg_we)
        begin
            default_retry_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            request_byte_reg <= '0;
            data_shift_reg   <= '0;
            ack_bits_reg     <= '0;
            retries_left_reg <= '0;
            parity_acc_reg   <= 1'b0;
            final_status_reg <= ST_OK;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg        <= phase_next;
                bit_count_reg    <= bit_count_next;
                request_byte_reg <= request_byte_next;
                data_shift_reg   <= data_shift_next;
                ack_bits_reg     <= ack_bits_next;
                retries_left_reg <= retries_left_next;
                parity_acc_reg   <= parity_acc_next;
                final_status_reg <= final_status_next;
            end
            if (item_ready)
            begin
                res_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[hdl/swd_host_packet_engine_unit.sv]
// ----------------------------------------------------------------------------
// swd_host_packet_engine_unit
// SWD host engine: each request is one SWCLK period, each result gives the
// SWDIO drive for that period plus busy, done, status and read data.
// Path from request accept to result valid: the input register, then the
// sequencer step into the result register.
// Throughput: 1 request per cycle while m_tready is high, set by the single-step sequencer.
// Reset: rst_n clears the sequencer to idle and default_retry to 100.
// ----------------------------------------------------------------------------
module swd_host_packet_engine_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [7:0]                           cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] operation, [2] ap_not_dp, [3] read_not_write, [5:4] reg_addr,
    // [37:6] wr_word, [45:38] retry_limit, [46] swdio_in, [47] ignored
    input  logic [swd_pe_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] swdio_out, [1] swdio_oe, [2] busy_res, [3] done_res,
    // [6:4] status, [38:7] rd_word, [39] zero
    output logic [swd_pe_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import swd_pe_pkg::*;

    swd_pe_item_t   in_item;
    swd_pe_item_t   item;
    logic           item_valid;
    logic           item_ready;
    swd_pe_result_t res;

    assign in_item = s_tdata[$bits(swd_pe_item_t)-1:0];
    assign m_tdata = {{(OUT_TDATA_W - $bits(swd_pe_result_t)){1'b0}}, res};

    swd_pe_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    swd_pe_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

endmodule
